// File: design/gbn_pkg.sv
// Shared constants and codes for the go-back-N sender.
package gbn_pkg;

  localparam int BufferDepthDef = 1024;
  localparam int MaxWindowDef   = 32;
  localparam int ResultCap      = 32;
  localparam int PayloadBytes   = 20;
  localparam int PayloadW       = 8 * PayloadBytes;
  localparam int SeqW           = 31;
  localparam int WordW          = 32;
  localparam int WinW           = 6;
  localparam int InDataW        = 256;
  localparam int OutDataW       = 232;

  localparam logic [WinW-1:0] WindowReset = 6'd8;
  localparam logic [SeqW-1:0] SeqLimit    = 31'h7FFF_FFFF;

  localparam logic [1:0] ActMsg     = 2'd0;
  localparam logic [1:0] ActAck     = 2'd1;
  localparam logic [1:0] ActTimeout = 2'd2;

  localparam logic [1:0] TmrNone  = 2'd0;
  localparam logic [1:0] TmrStop  = 2'd1;
  localparam logic [1:0] TmrStart = 2'd2;

endpackage

// File: design/go_back_n_sender.sv
// Go-back-N sender: message buffer, window control and packet emission.
//
// Input beats arrive on the s_axis channel: tuser carries the kind (new message,
// acknowledgment or timer expiry) and tdata the acknowledgment fields and the 20
// payload bytes. Every input beat yields one or more output beats on m_axis;
// tlast marks the final one, tuser flags a beat that carries a packet, and tdata
// holds the packet, the timer command and the drop flag.
// The block works on one input beat at a time and is not ready meanwhile.
// A message is summed into its checksum one payload byte at a time on a shared
// byte adder and then stored; an acknowledgment is checked on the same adder.
// A timer expiry uses a shared multiplier that finds the buffer slot of the
// window base by reciprocal multiplication. After that, each emitted beat goes
// through a memory read, an output load and the handshake, plus any receiver
// stall. A stalled receiver simply holds the block in its output state; nothing
// is lost. Reset clears the window, the counters and the window size (8); the
// message memory is not cleared, and only slots that were written are ever read.
// The cfg channel writes the window size register; the user must write it only
// while the block is idle, which the block itself does not enforce.
module go_back_n_sender
  import gbn_pkg::*;
#(
  parameter int BufferDepth = BufferDepthDef,
  parameter int MaxWindow   = MaxWindowDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [WinW-1:0]     cfg_data_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // rx_seq, rx_ack, rx_checksum, payload_w0, payload_w1, payload_w2, zero pad.
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // action.
  input  logic [1:0]          s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // packet_seq, packet_checksum, out_payload_w0, out_payload_w1, out_payload_w2,
  // timer_command, message_dropped, zero pad.
  output logic [OutDataW-1:0] m_axis_tdata_o,
  // packet_valid.
  output logic                m_axis_tuser_o,
  output logic                m_axis_tlast_o
);

  localparam int AW       = $clog2(BufferDepth);
  localparam int EmitCap  = (MaxWindow < ResultCap) ? MaxWindow : ResultCap;
  localparam int CapW     = $clog2(EmitCap + 1);
  localparam int EntryW   = WordW + PayloadW;
  localparam int MulW     = SeqW + WordW;
  localparam int ModSteps = 3;
  localparam logic [WordW-1:0] Recip = WordW'((64'd1 << WordW) / 64'(BufferDepth));

  typedef enum logic [6:0] {
    StIdle   = 7'b0000001,
    StSum    = 7'b0000010,
    StDecide = 7'b0000100,
    StMod    = 7'b0001000,
    StLoop   = 7'b0010000,
    StFetch  = 7'b0100000,
    StOut    = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [1:0]          act_q;
  logic [WordW-1:0]    ack_q, chk_q;
  logic [PayloadW-1:0] pay_q;
  logic [WordW-1:0]    acc_q, acc_d;
  logic [4:0]          step_q, step_d;
  logic [WinW-1:0]     win_q, win_d;
  logic [WordW-1:0]    base_q, base_d;
  logic [SeqW-1:0]     nts_q, nts_d, cnt_q, cnt_d, ptr_q, ptr_d, div_q, div_d;
  logic [AW-1:0]       wr_slot_q, wr_slot_d, nts_slot_q, nts_slot_d;
  logic [AW-1:0]       rd_slot_q, rd_slot_d;
  logic [MulW-1:0]     prod_q, prod_d, mul_p;
  logic [SeqW-1:0]     mul_a;
  logic [WordW-1:0]    mul_b;
  logic [CapW-1:0]     k_q, k_d, n_q, n_d;
  logic [1:0]          tmr_q, tmr_d;

  logic                opv_q, opv_d, olast_q, olast_d, odrop_q, odrop_d;
  logic [1:0]          otmr_q, otmr_d;
  logic [SeqW-1:0]     oseq_q, oseq_d;
  logic [WordW-1:0]    ochk_q;
  logic [63:0]         ow0_q, ow1_q;
  logic [WordW-1:0]    ow2_q;

  logic [EntryW-1:0]   mem [BufferDepth];
  logic [EntryW-1:0]   rdata_q;
  logic                mem_we, mem_re, load_pkt, load_empty;

  logic [7:0]          cur_byte;
  logic [WinW-1:0]     eff_win;
  logic [WordW:0]      win_end;
  logic                more, drop, send;
  logic [WordW-1:0]    occ;
  logic [SeqW-1:0]     span;
  logic [CapW-1:0]     span_cap;
  logic [AW:0]         mod_t;
  logic [AW-1:0]       mod_next;
  logic [1:0]          final_tmr;

  function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
    slot_inc = (s == AW'(BufferDepth - 1)) ? '0 : s + 1'b1;
  endfunction

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == StIdle);
  assign m_axis_tvalid_o = (state_q == StOut);
  assign m_axis_tuser_o  = opv_q;
  assign m_axis_tlast_o  = olast_q;
  assign m_axis_tdata_o  = {6'd0, odrop_q, otmr_q, ow2_q, ow1_q, ow0_q, ochk_q, oseq_q};

  assign cur_byte = pay_q[8*step_q +: 8];
  assign eff_win  = ({1'b0, win_q} > 7'(MaxWindow)) ? WinW'(MaxWindow) : win_q;
  assign win_end  = {1'b0, base_q} + (WordW+1)'(eff_win);
  assign send     = {2'b00, nts_q} < win_end;
  assign occ      = ({1'b0, cnt_q} > base_q) ? ({1'b0, cnt_q} - base_q) : '0;
  assign drop     = (occ >= WordW'(BufferDepth)) || (cnt_q == SeqLimit);
  assign span     = nts_q - base_q[SeqW-1:0];
  assign span_cap = (span > SeqW'(EmitCap)) ? CapW'(EmitCap) : span[CapW-1:0];
  assign mul_a    = (step_q == '0) ? div_q : prod_q[MulW-1 -: SeqW];
  assign mul_b    = (step_q == '0) ? Recip : WordW'(BufferDepth);
  assign mul_p    = MulW'(mul_a) * MulW'(mul_b);
  assign mod_t    = (AW+1)'(div_q - prod_q[SeqW-1:0]);
  assign mod_next = (mod_t >= (AW+1)'(BufferDepth)) ?
                    AW'(mod_t - (AW+1)'(BufferDepth)) : mod_t[AW-1:0];
  assign final_tmr = (act_q == ActAck) ?
                     (({1'b0, nts_q} == base_q) ? TmrStop : TmrStart) : tmr_q;

  always_comb begin
    if (act_q == ActAck) begin
      more = send && (nts_q < cnt_q) && (k_q < CapW'(EmitCap));
    end else begin
      more = (k_q < n_q);
    end
  end

  always_comb begin
    state_d    = state_q;
    acc_d      = acc_q;
    step_d     = step_q;
    win_d      = win_q;
    base_d     = base_q;
    nts_d      = nts_q;
    cnt_d      = cnt_q;
    ptr_d      = ptr_q;
    div_d      = div_q;
    wr_slot_d  = wr_slot_q;
    nts_slot_d = nts_slot_q;
    rd_slot_d  = rd_slot_q;
    prod_d     = prod_q;
    k_d        = k_q;
    n_d        = n_q;
    tmr_d      = tmr_q;
    opv_d      = opv_q;
    olast_d    = olast_q;
    odrop_d    = odrop_q;
    otmr_d     = otmr_q;
    oseq_d     = oseq_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    load_pkt   = 1'b0;
    load_empty = 1'b0;

    if (cfg_valid_i) begin
      win_d = cfg_data_i;
    end

    case (state_q)
      StIdle: begin
        if (s_axis_tvalid_i) begin
          step_d = '0;
          if (s_axis_tuser_i == ActAck) begin
            acc_d = s_axis_tdata_i[62:31] + {1'b0, s_axis_tdata_i[30:0]};
          end else begin
            acc_d = {1'b0, cnt_q};
          end
          if (s_axis_tuser_i == ActMsg || s_axis_tuser_i == ActAck) begin
            state_d = StSum;
          end else begin
            state_d = StDecide;
          end
        end
      end
      StSum: begin
        acc_d  = acc_q + {{24{cur_byte[7]}}, cur_byte};
        step_d = step_q + 5'd1;
        if (step_q == 5'(PayloadBytes - 1)) begin
          state_d = StDecide;
        end
      end
      StDecide: begin
        case (act_q)
          ActMsg: begin
            if (drop) begin
              load_empty = 1'b1;
              opv_d      = 1'b0;
              oseq_d     = '0;
              odrop_d    = 1'b1;
              otmr_d     = TmrNone;
              olast_d    = 1'b1;
              state_d    = StOut;
            end else begin
              mem_we    = 1'b1;
              cnt_d     = cnt_q + 1'b1;
              wr_slot_d = slot_inc(wr_slot_q);
              if (send) begin
                tmr_d     = ({1'b0, nts_q} == base_q) ? TmrStart : TmrNone;
                n_d       = CapW'(1);
                k_d       = '0;
                ptr_d     = nts_q;
                rd_slot_d = nts_slot_q;
                state_d   = StLoop;
              end else begin
                load_empty = 1'b1;
                opv_d      = 1'b0;
                oseq_d     = '0;
                odrop_d    = 1'b0;
                otmr_d     = TmrNone;
                olast_d    = 1'b1;
                state_d    = StOut;
              end
            end
          end
          ActAck: begin
            if (acc_q != chk_q) begin
              load_empty = 1'b1;
              opv_d      = 1'b0;
              oseq_d     = '0;
              odrop_d    = 1'b0;
              otmr_d     = TmrNone;
              olast_d    = 1'b1;
              state_d    = StOut;
            end else begin
              base_d    = ack_q[WordW-1] ? '0 : ack_q + 1'b1;
              k_d       = '0;
              ptr_d     = nts_q;
              rd_slot_d = nts_slot_q;
              state_d   = StLoop;
            end
          end
          ActTimeout: begin
            n_d     = ({1'b0, nts_q} > base_q) ? span_cap : '0;
            k_d     = '0;
            ptr_d   = base_q[SeqW-1:0];
            tmr_d   = TmrStart;
            div_d   = base_q[SeqW-1:0];
            step_d  = '0;
            state_d = StMod;
          end
          default: begin
            load_empty = 1'b1;
            opv_d      = 1'b0;
            oseq_d     = '0;
            odrop_d    = 1'b0;
            otmr_d     = TmrNone;
            olast_d    = 1'b1;
            state_d    = StOut;
          end
        endcase
      end
      StMod: begin
        prod_d = mul_p;
        step_d = step_q + 5'd1;
        if (step_q == 5'(ModSteps - 1)) begin
          rd_slot_d = mod_next;
          state_d   = StLoop;
        end
      end
      StLoop: begin
        if (more) begin
          mem_re    = 1'b1;
          oseq_d    = ptr_q;
          ptr_d     = ptr_q + 1'b1;
          k_d       = k_q + 1'b1;
          rd_slot_d = slot_inc(rd_slot_q);
          if (act_q != ActTimeout) begin
            nts_d      = nts_q + 1'b1;
            nts_slot_d = slot_inc(nts_slot_q);
          end
          state_d = StFetch;
        end else begin
          load_empty = 1'b1;
          opv_d      = 1'b0;
          oseq_d     = '0;
          odrop_d    = 1'b0;
          otmr_d     = final_tmr;
          olast_d    = 1'b1;
          state_d    = StOut;
        end
      end
      StFetch: begin
        load_pkt = 1'b1;
        opv_d    = 1'b1;
        odrop_d  = 1'b0;
        olast_d  = !more;
        otmr_d   = more ? TmrNone : final_tmr;
        state_d  = StOut;
      end
      StOut: begin
        if (m_axis_tready_i) begin
          state_d = olast_q ? StIdle : StLoop;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      win_q      <= WindowReset;
      base_q     <= '0;
      nts_q      <= '0;
      cnt_q      <= '0;
      wr_slot_q  <= '0;
      nts_slot_q <= '0;
      rd_slot_q  <= '0;
      step_q     <= '0;
      k_q        <= '0;
      n_q        <= '0;
      tmr_q      <= TmrNone;
      opv_q      <= 1'b0;
      olast_q    <= 1'b0;
      odrop_q    <= 1'b0;
      otmr_q     <= TmrNone;
    end else begin
      state_q    <= state_d;
      win_q      <= win_d;
      base_q     <= base_d;
      nts_q      <= nts_d;
      cnt_q      <= cnt_d;
      wr_slot_q  <= wr_slot_d;
      nts_slot_q <= nts_slot_d;
      rd_slot_q  <= rd_slot_d;
      step_q     <= step_d;
      k_q        <= k_d;
      n_q        <= n_d;
      tmr_q      <= tmr_d;
      opv_q      <= opv_d;
      olast_q    <= olast_d;
      odrop_q    <= odrop_d;
      otmr_q     <= otmr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    ptr_q  <= ptr_d;
    div_q  <= div_d;
    prod_q <= prod_d;
    oseq_q <= oseq_d;
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      act_q <= s_axis_tuser_i;
      ack_q <= s_axis_tdata_i[62:31];
      chk_q <= s_axis_tdata_i[94:63];
      pay_q <= s_axis_tdata_i[254:95];
    end
    if (load_pkt) begin
      ochk_q <= rdata_q[EntryW-1 -: WordW];
      ow0_q  <= rdata_q[63:0];
      ow1_q  <= rdata_q[127:64];
      ow2_q  <= rdata_q[159:128];
    end else if (load_empty) begin
      ochk_q <= '0;
      ow0_q  <= '0;
      ow1_q  <= '0;
      ow2_q  <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_slot_q] <= {acc_q, pay_q};
    end
    if (mem_re) begin
      rdata_q <= mem[rd_slot_q];
    end
  end

`ifndef SYNTHESIS
  a_nts_within_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nts_q <= cnt_q)
    else $error("send pointer passed the stored message count");

  a_one_side_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input accepted while a result is pending");

  a_timer_on_last_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tlast_o) |-> (otmr_q == TmrNone))
    else $error("timer command on a beat that is not the last");

  a_emit_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_q <= CapW'(EmitCap))
    else $error("more packets emitted than the result limit");

  a_drop_is_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && odrop_q) |-> (!opv_q && olast_q))
    else $error("dropped message flagged on a packet beat");
`endif

endmodule

// File: sim/tb_go_back_n_sender.sv
// Self-checking testbench for the go-back-N sender, with a predictor and beat-level checks.
`timescale 1ns / 1ps
module tb_go_back_n_sender;
  import gbn_pkg::*;

  localparam int HoldCycles    = 400;
  localparam int WatchdogLimit = 3000;
  localparam int EmitMax       = (MaxWindowDef < ResultCap) ? MaxWindowDef : ResultCap;
  localparam logic [1:0] ActReserved = 2'd3;

  typedef struct packed {
    logic              pkt_valid;
    logic [SeqW-1:0]   seq;
    logic [WordW-1:0]  checksum;
    logic [63:0]       w0;
    logic [63:0]       w1;
    logic [31:0]       w2;
    logic [1:0]        timer;
    logic              dropped;
    logic              last;
  } sender_beat_t;

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                cfg_valid = 1'b0;
  logic [WinW-1:0]     cfg_data  = '0;
  logic                cfg_ready;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata   = '0;
  logic [1:0]          s_tuser   = ActMsg;
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                m_tuser;
  logic                m_tlast;

  logic [WinW-1:0]     win_setting  = WindowReset;
  logic [31:0]         win_base     = '0;
  logic [31:0]         send_next    = '0;
  logic [31:0]         stored_total = '0;
  logic [WordW-1:0]    slot_checksum [BufferDepthDef];
  logic [PayloadW-1:0] slot_payload  [BufferDepthDef];
  sender_beat_t        expected_beats [$];

  int mismatches    = 0;
  int idle_cycles   = 0;
  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  bit hold_req      = 1'b0;

  go_back_n_sender u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [31:0] signed_byte_sum(input logic [PayloadW-1:0] pl);
    logic [31:0] s;
    int i;
    s = '0;
    for (i = 0; i < PayloadBytes; i++) s = s + {{24{pl[8*i+7]}}, pl[8*i +: 8]};
    return s;
  endfunction

  function automatic sender_beat_t packet_beat(input logic [31:0] seq);
    sender_beat_t b;
    int slot;
    slot = seq % BufferDepthDef;
    b = '0;
    b.pkt_valid = 1'b1;
    b.seq = seq[SeqW-1:0];
    b.checksum = slot_checksum[slot];
    b.w0 = slot_payload[slot][63:0];
    b.w1 = slot_payload[slot][127:64];
    b.w2 = slot_payload[slot][159:128];
    return b;
  endfunction

  task automatic predict_sender_beats(input logic [1:0] kind, input logic [InDataW-1:0] d);
    sender_beat_t run [$];
    sender_beat_t b;
    logic [PayloadW-1:0] pl;
    logic [31:0] occ, ack, win, n, i;
    logic [32:0] limit;
    logic [1:0] tmr;
    logic drop;
    int slot;
    pl = d[95 +: PayloadW];
    win = (win_setting > MaxWindowDef) ? MaxWindowDef : win_setting;
    tmr = TmrNone;
    drop = 1'b0;
    case (kind)
      ActMsg: begin
        occ = (stored_total > win_base) ? stored_total - win_base : '0;
        if (occ >= BufferDepthDef || stored_total >= {1'b0, SeqLimit}) begin
          drop = 1'b1;
        end else begin
          slot = stored_total % BufferDepthDef;
          slot_checksum[slot] = stored_total + signed_byte_sum(pl);
          slot_payload[slot] = pl;
          stored_total = stored_total + 1;
          if ({1'b0, send_next} < {1'b0, win_base} + win && send_next < stored_total) begin
            run.push_back(packet_beat(send_next));
            if (win_base == send_next) tmr = TmrStart;
            send_next = send_next + 1;
          end
        end
      end
      ActAck: begin
        ack = d[62:31];
        if (ack + {1'b0, d[30:0]} + signed_byte_sum(pl) == d[94:63]) begin
          win_base = ack[31] ? '0 : ack + 1;
          limit = {1'b0, win_base} + win;
          while ({1'b0, send_next} < limit && send_next < stored_total &&
                 run.size() < EmitMax) begin
            run.push_back(packet_beat(send_next));
            send_next = send_next + 1;
          end
          tmr = (win_base == send_next) ? TmrStop : TmrStart;
        end
      end
      ActTimeout: begin
        n = (send_next > win_base) ? send_next - win_base : '0;
        if (n > EmitMax) n = EmitMax;
        for (i = 0; i < n; i++) run.push_back(packet_beat(win_base + i));
        tmr = TmrStart;
      end
      default: ;
    endcase
    if (run.size() == 0) run.push_back('0);
    b = run.pop_back();
    b.timer = tmr;
    b.dropped = drop;
    b.last = 1'b1;
    run.push_back(b);
    foreach (run[j]) expected_beats.push_back(run[j]);
  endtask

  function automatic logic [InDataW-1:0] random_data();
    logic [InDataW-1:0] d;
    int i;
    for (i = 0; i < InDataW / 32; i++) d[32*i +: 32] = $urandom;
    d[InDataW-1] = 1'b0;
    return d;
  endfunction

  function automatic logic [InDataW-1:0] msg_item(input logic [PayloadW-1:0] pl);
    logic [InDataW-1:0] d;
    d = random_data();
    d[95 +: PayloadW] = pl;
    return d;
  endfunction

  function automatic logic [InDataW-1:0] ack_item(input logic [31:0] ack, input bit corrupt);
    logic [InDataW-1:0] d;
    logic [31:0] chk;
    d = random_data();
    d[62:31] = ack;
    chk = ack + {1'b0, d[30:0]} + signed_byte_sum(d[95 +: PayloadW]);
    if (corrupt) chk = chk ^ (32'd1 << $urandom_range(31));
    d[94:63] = chk;
    return d;
  endfunction

  function automatic logic [31:0] in_window_ack();
    if (send_next > win_base) return win_base - 1 + $urandom_range(send_next - win_base);
    return send_next - 1 + $urandom_range(2);
  endfunction

  task automatic send_item(input logic [1:0] kind, input logic [InDataW-1:0] d);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= d;
    do @(posedge clk_i); while (!s_tready);
    predict_sender_beats(kind, d);
  endtask

  task automatic drain_beats();
    s_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_window(input logic [WinW-1:0] w);
    drain_beats();
    cfg_valid <= 1'b1;
    cfg_data <= w;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    win_setting = w;
  endtask

  task automatic send_random_item();
    int r;
    logic [31:0] ack;
    r = $urandom_range(99);
    if (r < 42) begin
      send_item(ActMsg, random_data());
    end else if (r < 77) begin
      send_item(ActAck, ack_item(in_window_ack(), 1'b0));
    end else if (r < 89) begin
      send_item(ActTimeout, random_data());
    end else if (r < 94) begin
      send_item(ActAck, ack_item(in_window_ack(), 1'b1));
    end else if (r < 98) begin
      case ($urandom_range(2))
        0: ack = {1'b1, 31'($urandom)};
        1: ack = send_next + $urandom_range(40);
        default: ack = $urandom_range(send_next) - 1;
      endcase
      send_item(ActAck, ack_item(ack, 1'b0));
    end else begin
      send_item(ActReserved, random_data());
    end
  endtask

  task automatic test_directed_cases();
    int k;
    send_item(ActTimeout, random_data());
    send_item(ActReserved, random_data());
    send_item(ActAck, ack_item(32'd0, 1'b1));
    send_item(ActMsg, msg_item('0));
    send_item(ActMsg, msg_item('1));
    send_item(ActMsg, msg_item({PayloadBytes{8'h7F}}));
    send_item(ActMsg, msg_item({PayloadBytes{8'h80}}));
    for (k = 0; k < 6; k++) send_item(ActMsg, random_data());
    send_item(ActAck, ack_item(32'd2, 1'b0));
    send_item(ActTimeout, random_data());
    send_item(ActAck, ack_item(32'hFFFF_FFFF, 1'b0));
    send_item(ActAck, ack_item(32'h8000_0000, 1'b0));
    send_item(ActAck, ack_item(32'd9, 1'b0));
    send_item(ActAck, ack_item(32'd20, 1'b0));
    send_item(ActMsg, random_data());
    send_item(ActTimeout, random_data());
    send_item(ActAck, ack_item(32'h7FFF_FFFF, 1'b0));
    send_item(ActMsg, random_data());
    send_item(ActAck, ack_item(32'd5, 1'b0));
    send_item(ActTimeout, random_data());
    drain_beats();
  endtask

  // The receiver holds off while the sender keeps offering, so the input stalls.
  task automatic test_backpressure();
    int k;
    write_window(6'd32);
    src_idle_pct = 0;
    snk_stall_pct = 0;
    hold_req = 1'b1;
    for (k = 0; k < 8; k++) send_item(ActMsg, random_data());
    send_item(ActTimeout, random_data());
    drain_beats();
  endtask

  task automatic test_random_traffic(input int items, input logic [WinW-1:0] w,
                                     input int src_pct, input int snk_pct);
    int k;
    write_window(w);
    src_idle_pct = src_pct;
    snk_stall_pct = snk_pct;
    for (k = 0; k < items; k++) send_random_item();
    drain_beats();
  endtask

  // Builds a backlog behind a one-packet window, then releases and resends up to the beat cap.
  task automatic test_release_and_resend();
    int k;
    write_window(6'd1);
    src_idle_pct = 0;
    snk_stall_pct = 0;
    send_item(ActAck, ack_item(stored_total - 1, 1'b0));
    for (k = 0; k < 40; k++) send_item(ActMsg, random_data());
    write_window(6'd32);
    send_item(ActAck, ack_item(win_base - 1, 1'b0));
    send_item(ActTimeout, random_data());
    send_item(ActAck, ack_item(win_base - 101, 1'b0));
    send_item(ActTimeout, random_data());
    drain_beats();
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    sender_beat_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual %h", $time, m_tdata);
        mismatches++;
      end else begin
        want = expected_beats.pop_front();
        check_field("packet_valid", 64'(want.pkt_valid), 64'(m_tuser));
        check_field("packet_seq", 64'(want.seq), 64'(m_tdata[30:0]));
        check_field("packet_checksum", 64'(want.checksum), 64'(m_tdata[62:31]));
        check_field("out_payload_w0", want.w0, m_tdata[126:63]);
        check_field("out_payload_w1", want.w1, m_tdata[190:127]);
        check_field("out_payload_w2", 64'(want.w2), 64'(m_tdata[222:191]));
        check_field("timer_command", 64'(want.timer), 64'(m_tdata[224:223]));
        check_field("message_dropped", 64'(want.dropped), 64'(m_tdata[225]));
        check_field("last", 64'(want.last), 64'(m_tlast));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles++;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_backpressure();
    test_random_traffic(100, 6'd8, 0, 0);
    test_random_traffic(80, 6'd63, 45, 0);
    test_random_traffic(80, 6'd32, 0, 45);
    test_random_traffic(40, 6'd0, 27, 27);
    test_random_traffic(80, 6'($urandom_range(2, 31)), 27, 27);
    test_release_and_resend();
    drain_beats();
    repeat (150) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: go_back_n_sender.f
design/gbn_pkg.sv
design/go_back_n_sender.sv
sim/tb_go_back_n_sender.sv
